[design/longest_prefix_route_lookup_unit_defines.svh]
// ---------------------------------------------------------------------------
// longest_prefix_route_lookup_unit_defines
// assertion macros used by the route lookup top module
// ---------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define LPRL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define LPRL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lprl_pkg.sv]
// ---------------------------------------------------------------------------
// lprl_pkg
// types and constants of the longest prefix route lookup unit
// ---------------------------------------------------------------------------
package lprl_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int PORT_COUNT    = 4;
    localparam int ADDR_W        = 32;
    localparam int IDX_W         = 4;
    localparam int PORT_W        = 2;

    // transaction function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [ADDR_W-1:0] NO_GATEWAY = 32'h0000_0000;

    typedef logic [IDX_W-1:0]  lprl_idx_t;
    typedef logic [PORT_W-1:0] lprl_port_t;
    typedef logic [ADDR_W-1:0] lprl_addr_t;

    typedef struct packed {
        logic       func;
        lprl_idx_t  entry_index;
        logic       entry_valid;
        lprl_addr_t route_prefix;
        lprl_addr_t route_mask;
        lprl_addr_t route_gateway;
        lprl_port_t route_port;
        lprl_addr_t lookup_address;
    } lprl_req_t;

    typedef struct packed {
        logic       found;
        lprl_idx_t  match_index;
        lprl_addr_t match_mask;
        lprl_addr_t next_hop;
        lprl_port_t out_port;
    } lprl_rsp_t;

    // table write broadcast to every cell
    typedef struct packed {
        logic       en;
        lprl_idx_t  index;
        logic       valid;
        lprl_addr_t prefix;
        lprl_addr_t mask;
        lprl_addr_t gateway;
        lprl_port_t port;
    } lprl_wr_t;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic       active;
        lprl_addr_t addr;
        logic       hit;
        lprl_idx_t  idx;
        lprl_addr_t mask;
        lprl_addr_t gateway;
        lprl_port_t port;
    } lprl_scan_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } lprl_state_t;

    function automatic lprl_port_t clamp_port(input lprl_port_t raw);
        lprl_port_t p;
        p = raw;
        if (int'(raw) >= PORT_COUNT)
        begin
            p = PORT_W'(PORT_COUNT - 1);
        end
        return p;
    endfunction

endpackage

[design/lprl_cell.sv]
// ---------------------------------------------------------------------------
// lprl_cell
// one routing table slot and one compare step of the lookup chain
// ---------------------------------------------------------------------------
module lprl_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  lprl_pkg::lprl_idx_t  cell_id,
    input  lprl_pkg::lprl_wr_t   wr,
    input  lprl_pkg::lprl_scan_t scan_in,
    output lprl_pkg::lprl_scan_t scan_out
);
    import lprl_pkg::*;

    logic       valid_reg;
    lprl_addr_t prefix_reg;
    lprl_addr_t mask_reg;
    lprl_addr_t gateway_reg;
    lprl_port_t port_reg;
    logic       active_reg;
    lprl_scan_t scan_reg;
    lprl_scan_t scan_next;
    logic       wr_hit;
    logic       match;

    assign wr_hit = wr.en && (wr.index == cell_id);

    // slot storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_hit)
        begin
            valid_reg <= wr.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            prefix_reg  <= wr.prefix;
            mask_reg    <= wr.mask;
            gateway_reg <= wr.gateway;
            port_reg    <= wr.port;
        end
    end

    // compare step, ascending slot order keeps the lowest index on a tie
    always_comb
    begin
        match = valid_reg
             && ((scan_in.addr & mask_reg) == (prefix_reg & mask_reg))
             && (!scan_in.hit || (mask_reg > scan_in.mask));
        scan_next = scan_in;
        if (match)
        begin
            scan_next.hit     = 1'b1;
            scan_next.idx     = cell_id;
            scan_next.mask    = mask_reg;
            scan_next.gateway = gateway_reg;
            scan_next.port    = port_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= scan_in.active;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    always_comb
    begin
        scan_out        = scan_reg;
        scan_out.active = active_reg;
    end

endmodule

[design/longest_prefix_route_lookup_unit.sv]
// ---------------------------------------------------------------------------
// longest_prefix_route_lookup_unit
// ipv4 longest prefix match over a chain of routing table cells
// ---------------------------------------------------------------------------
// usage
//   req carries one transaction on req_valid / req_ready: func selects a
//   table write or an address lookup. rsp returns exactly one transaction
//   per request on rsp_valid / rsp_ready.
//   a write updates its slot in the accepting cycle and its all-zero
//   response is registered then and valid in the following cycle.
//   a lookup token walks the row of TABLE_ENTRIES cells, one cell per
//   cycle; the length of that row sets the lookup time: the response is
//   registered after the token leaves the last cell, and the next request
//   can be taken once the control is back in idle.
//   only one transaction is in flight; req_ready is low during a walk.
//   the response sits in an output register, so req can be taken in the
//   same cycle that a pending response is taken.
//   if the receiver stalls, the response holds and req_ready stays low
//   until rsp_ready returns.
//   reset clears all slot valid marks at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "longest_prefix_route_lookup_unit_defines.svh"

module longest_prefix_route_lookup_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lprl_pkg::lprl_req_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lprl_pkg::lprl_rsp_t  rsp
);
    import lprl_pkg::*;

    lprl_state_t state_reg;
    lprl_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    lprl_rsp_t   rsp_reg;
    lprl_rsp_t   rsp_next;
    logic        req_accept;
    lprl_wr_t    wr;
    lprl_scan_t  scan_head;
    lprl_scan_t  scan_link [0:TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] cell_active;
    lprl_scan_t  scan_done;

    assign req_accept = req_valid && req_ready;

    // write broadcast, out-of-range slots are dropped
    always_comb
    begin
        wr.en      = req_accept && (req.func == FUNC_WRITE)
                  && (int'(req.entry_index) < TABLE_ENTRIES);
        wr.index   = req.entry_index;
        wr.valid   = req.entry_valid;
        wr.prefix  = req.route_prefix;
        wr.mask    = req.route_mask;
        wr.gateway = req.route_gateway;
        wr.port    = clamp_port(req.route_port);
    end

    // lookup token entering the first cell
    always_comb
    begin
        scan_head         = '0;
        scan_head.active  = req_accept && (req.func == FUNC_LOOKUP);
        scan_head.addr    = req.lookup_address;
    end

    assign scan_link[0] = scan_head;

    // the row of cells, each owns one slot
    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        lprl_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_id  (IDX_W'(g)),
            .wr       (wr),
            .scan_in  (scan_link[g]),
            .scan_out (scan_link[g+1])
        );
        assign cell_active[g] = scan_link[g+1].active;
    end

    assign scan_done = scan_link[TABLE_ENTRIES];

    // control: idle takes requests, scan waits for the token to leave
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = !rsp_valid_reg || rsp_ready;
                if (req_accept)
                begin
                    if (req.func == FUNC_LOOKUP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // write response is all zero
                        rsp_valid_next = 1'b1;
                        rsp_next       = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done.active)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (scan_done.hit)
                    begin
                        rsp_next.found       = 1'b1;
                        rsp_next.match_index = scan_done.idx;
                        rsp_next.match_mask  = scan_done.mask;
                        rsp_next.next_hop    = (scan_done.gateway == NO_GATEWAY)
                                             ? scan_done.addr : scan_done.gateway;
                        rsp_next.out_port    = scan_done.port;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `LPRL_ASSERT_IMP(a_one_token, 1'b1, $onehot0(cell_active),
        "more than one lookup token in the cell row")
    `LPRL_ASSERT_IMP(a_token_scan, (cell_active != '0), (state_reg == ST_SCAN),
        "lookup token present outside a scan")
    `LPRL_ASSERT_NXT(a_done_rsp, (state_reg == ST_SCAN) && scan_done.active,
        rsp_valid && (state_reg == ST_IDLE),
        "finished lookup did not load the response register")
    `LPRL_ASSERT_NXT(a_lookup_start, req_accept && (req.func == FUNC_LOOKUP),
        scan_link[1].active,
        "accepted lookup did not enter the first cell")
    `LPRL_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp.found,
        (rsp.match_index == '0) && (rsp.match_mask == '0)
        && (rsp.next_hop == '0) && (rsp.out_port == '0),
        "response without a match carries nonzero fields")

endmodule

[tb/lprl_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lprl_checker
// predicts route lookup responses and compares them in order of arrival
// ---------------------------------------------------------------------------
module lprl_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  lprl_pkg::lprl_req_t  req,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  lprl_pkg::lprl_rsp_t  rsp,
    output int                  errors,
    output int                  pending
);
    import lprl_pkg::*;

    logic       tbl_live    [TABLE_ENTRIES];
    lprl_addr_t tbl_prefix  [TABLE_ENTRIES];
    lprl_addr_t tbl_mask    [TABLE_ENTRIES];
    lprl_addr_t tbl_gateway [TABLE_ENTRIES];
    lprl_port_t tbl_port    [TABLE_ENTRIES];

    lprl_rsp_t  route_results_q[$];

    // applies one request to the table copy and returns the response it earns
    function automatic lprl_rsp_t resolve_route(input lprl_req_t t);
        lprl_rsp_t  r;
        logic       hit;
        lprl_addr_t gw;
        int         i;
        r   = '0;
        hit = 1'b0;
        if (t.func == FUNC_WRITE)
        begin
            if (int'(t.entry_index) < TABLE_ENTRIES)
            begin
                tbl_live[t.entry_index]    = t.entry_valid;
                tbl_prefix[t.entry_index]  = t.route_prefix;
                tbl_mask[t.entry_index]    = t.route_mask;
                tbl_gateway[t.entry_index] = t.route_gateway;
                tbl_port[t.entry_index]    = (int'(t.route_port) >= PORT_COUNT) ?
                                             PORT_W'(PORT_COUNT - 1) : t.route_port;
            end
            return r;
        end
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (tbl_live[i] &&
                ((t.lookup_address & tbl_mask[i]) == (tbl_prefix[i] & tbl_mask[i])) &&
                (!hit || tbl_mask[i] > r.match_mask))
            begin
                hit           = 1'b1;
                r.match_index = IDX_W'(i);
                r.match_mask  = tbl_mask[i];
            end
        end
        if (hit)
        begin
            gw         = tbl_gateway[r.match_index];
            r.found    = 1'b1;
            r.next_hop = (gw == NO_GATEWAY) ? t.lookup_address : gw;
            r.out_port = tbl_port[r.match_index];
        end
        return r;
    endfunction

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lprl_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                tbl_live[i] = 1'b0;
            end
            route_results_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // response transaction against the oldest prediction
            if (rsp_valid && rsp_ready)
            begin
                if (route_results_q.size() == 0)
                begin
                    $error("response transaction with nothing outstanding");
                    errors++;
                end
                else
                begin
                    want = route_results_q.pop_front();
                    errors += field_mismatch("found", 32'(want.found), 32'(rsp.found));
                    errors += field_mismatch("match_index", 32'(want.match_index),
                                             32'(rsp.match_index));
                    errors += field_mismatch("match_mask", want.match_mask, rsp.match_mask);
                    errors += field_mismatch("next_hop", want.next_hop, rsp.next_hop);
                    errors += field_mismatch("out_port", 32'(want.out_port),
                                             32'(rsp.out_port));
                end
            end
            if (req_valid && req_ready)
            begin
                route_results_q.push_back(resolve_route(req));
            end
            pending = route_results_q.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// drives table writes and address lookups into the route lookup unit with
// random gaps and stalls; the checker beside the dut predicts every response
// ---------------------------------------------------------------------------
module testbench;

    import lprl_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    // length of the long receiver hold-off and the responses that start it
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT_A    = 40;
    localparam int HOLD_AT_B    = 450;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    lprl_req_t req;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    lprl_rsp_t rsp;

    int        chk_errors;
    int        chk_pending;

    // idle rates in percent, changed between phases
    int        send_gap_pct   = 0;
    int        recv_stall_pct = 0;

    // receiver bookkeeping
    int        rsp_taken;
    int        hold_left;

    // stimulus view of the table, used only to aim lookups at live routes
    logic       shadow_live   [TABLE_ENTRIES];
    lprl_addr_t shadow_prefix [TABLE_ENTRIES];
    lprl_addr_t shadow_mask   [TABLE_ENTRIES];
    // a few base networks so that random routes nest inside each other
    lprl_addr_t net_base [4];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    longest_prefix_route_lookup_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lprl_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .errors    (chk_errors),
        .pending   (chk_pending)
    );

    // receiver: random stalls plus a long hold-off at two points of the run,
    // during which the sender keeps offering and the dut must back up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_taken <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_taken <= rsp_taken + 1;
            end
            if (rsp_valid && rsp_ready && (rsp_taken == HOLD_AT_A || rsp_taken == HOLD_AT_B))
            begin
                hold_left <= LONG_HOLD;
                rsp_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // write transaction for one table slot, spare lookup field random
    function automatic lprl_req_t route_write(input int idx, input logic live,
                                              input lprl_addr_t prefix,
                                              input lprl_addr_t mask,
                                              input lprl_addr_t gateway,
                                              input int port);
        lprl_req_t t;
        t.func           = FUNC_WRITE;
        t.entry_index    = IDX_W'(idx);
        t.entry_valid    = live;
        t.route_prefix   = prefix;
        t.route_mask     = mask;
        t.route_gateway  = gateway;
        t.route_port     = PORT_W'(port);
        t.lookup_address = $urandom;
        return t;
    endfunction

    // lookup transaction, the unused write fields carry random junk
    function automatic lprl_req_t route_query(input lprl_addr_t addr);
        lprl_req_t t;
        t = route_write($urandom_range(0, TABLE_ENTRIES - 1), 1'($urandom_range(0, 1)),
                        $urandom, $urandom, $urandom, $urandom_range(0, 3));
        t.func           = FUNC_LOOKUP;
        t.lookup_address = addr;
        return t;
    endfunction

    // mostly contiguous masks over nested networks, some odd masks and
    // unmasked host bits left in the prefix
    function automatic lprl_req_t random_write();
        lprl_addr_t m;
        lprl_addr_t p;
        int         len;
        int         roll;
        roll = $urandom_range(0, 99);
        len  = (roll < 12) ? 0 : (roll < 25) ? ADDR_W : $urandom_range(1, ADDR_W - 1);
        m    = (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
        if ($urandom_range(0, 9) == 0)
        begin
            m = $urandom;
        end
        p = net_base[$urandom_range(0, 3)] ^ ($urandom & ~m);
        if ($urandom_range(0, 9) == 0)
        begin
            p = $urandom;
        end
        return route_write($urandom_range(0, TABLE_ENTRIES - 1),
                           $urandom_range(0, 99) < 85, p, m,
                           ($urandom_range(0, 99) < 30) ? NO_GATEWAY : lprl_addr_t'($urandom),
                           $urandom_range(0, 3));
    endfunction

    // lookups aimed inside a live route most of the time, sometimes one bit off
    function automatic lprl_req_t random_query();
        lprl_req_t  t;
        lprl_addr_t a;
        int         pick;
        t    = route_query($urandom);
        pick = $urandom_range(0, TABLE_ENTRIES - 1);
        if (shadow_live[pick] && $urandom_range(0, 99) < 80)
        begin
            a = (shadow_prefix[pick] & shadow_mask[pick]) | ($urandom & ~shadow_mask[pick]);
            if ($urandom_range(0, 9) == 0)
            begin
                a = a ^ (32'h1 << $urandom_range(0, ADDR_W - 1));
            end
            t.lookup_address = a;
        end
        return t;
    endfunction

    // offers one transaction and returns at the edge that accepts it
    task automatic send_item(input lprl_req_t item);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        if (item.func == FUNC_WRITE)
        begin
            shadow_live[item.entry_index]   = item.entry_valid;
            shadow_prefix[item.entry_index] = item.route_prefix;
            shadow_mask[item.entry_index]   = item.route_mask;
        end
    endtask

    initial
    begin
        int        n;
        int        roll;
        lprl_req_t noise;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        for (n = 0; n < TABLE_ENTRIES; n++)
        begin
            shadow_live[n] = 1'b0;
        end
        for (n = 0; n < 4; n++)
        begin
            net_base[n] = $urandom;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one: sender idles a little, receiver a lot
        send_gap_pct   <= 17;
        recv_stall_pct <= 68;

        // directed part
        // empty table gives no match
        send_item(route_query(32'hC0A8_0101));
        // default route with a gateway matches both address extremes
        send_item(route_write(0, 1'b1, $urandom, 32'h0000_0000, 32'h0A00_0001, 3));
        send_item(route_query(32'hFFFF_FFFF));
        send_item(route_query(32'h0000_0000));
        // directly attached /24, prefix carries host bits
        send_item(route_write(15, 1'b1, 32'hC0A8_0177, 32'hFFFF_FF00, NO_GATEWAY, 0));
        send_item(route_query(32'hC0A8_01FE));
        // host route beats the /24
        send_item(route_write(7, 1'b1, 32'hC0A8_0105, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2));
        send_item(route_query(32'hC0A8_0105));
        // same /24 at a lower slot wins the tie
        send_item(route_write(3, 1'b1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0102_0304, 1));
        send_item(route_query(32'hC0A8_0142));
        // non-contiguous mask compared as a number
        send_item(route_write(9, 1'b1, 32'h0A00_0B00, 32'hFF00_FF00, NO_GATEWAY, 2));
        send_item(route_query(32'h0A33_0B77));
        // removing the tie winner hands the match back to the other /24
        send_item(route_write(3, 1'b0, $urandom, $urandom, $urandom, 3));
        send_item(route_query(32'hC0A8_0142));
        // all-ones entry
        send_item(route_write(12, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3));
        send_item(route_query(32'hFFFF_FFFF));
        // second default route, the lower slot keeps winning
        send_item(route_write(12, 1'b1, 32'h0000_0000, 32'h0000_0000, NO_GATEWAY, 0));
        send_item(route_query(32'h1234_5678));
        // remove the first default, the directly attached one takes over
        send_item(route_write(0, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0));
        send_item(route_query(32'h1234_5678));
        send_item(route_query(32'hC0A8_0199));
        send_item(route_write(5, 1'b1, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0A0A_0A0A, 1));
        send_item(route_query(32'hC0A8_7F01));

        // random part in three idling phases
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_gap_pct   <= 68;
                recv_stall_pct <= 17;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_gap_pct   <= 0;
                recv_stall_pct <= 0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                noise = {$urandom, $urandom, $urandom, $urandom, 8'($urandom)};
                send_item(noise);
            end
            else if (roll < 40)
            begin
                send_item(random_write());
            end
            else
            begin
                send_item(random_query());
            end
        end
        req_valid <= 1'b0;

        // drain, then give any stray response time to show up
        do
        begin
            @(negedge clk);
        end
        while (chk_pending != 0);
        repeat (TABLE_ENTRIES + 8) @(posedge clk);

        if (chk_errors == 0)
        begin
            $display("[longest_prefix_route_lookup_unit] OK");
        end
        else
        begin
            $display("[longest_prefix_route_lookup_unit] ERROR");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("[longest_prefix_route_lookup_unit] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/lprl_pkg.sv
design/lprl_cell.sv
design/longest_prefix_route_lookup_unit.sv
tb/lprl_checker.sv
tb/testbench.sv
